FILE: sv/bsm_pkg.sv
// Package for the 3x3 box smoothing block: widths, data types, slot codes
// and the reciprocal table used to divide the window sums.
// No dependencies.
package bsm_pkg;

	localparam int MAX_DIM   = 1024;
	localparam int IDX_W     = $clog2(MAX_DIM);
	localparam int CFG_W     = 11;
	localparam int DIM_MIN   = 2;
	localparam int DIM_RESET = 512;
	localparam int POS_W     = 10;

	localparam int NUM_CH    = 3;
	localparam int CH_W      = 16;
	localparam int LOW_W     = CH_W + 1;
	localparam int COL_W     = CH_W + 2;
	localparam int SUM_W     = CH_W + 4;
	localparam int NUM_SLOTS = 4;

	localparam int RECIP_SHIFT = 24;
	localparam int RECIP_W     = RECIP_SHIFT - 1;
	localparam logic [RECIP_W-1:0] RECIP_4 = RECIP_W'((2 ** RECIP_SHIFT) / 4);
	localparam logic [RECIP_W-1:0] RECIP_6 = RECIP_W'((2 ** RECIP_SHIFT + 6 - 1) / 6);
	localparam logic [RECIP_W-1:0] RECIP_9 = RECIP_W'((2 ** RECIP_SHIFT + 9 - 1) / 9);

	typedef logic [CH_W-1:0]  chan_t;
	typedef logic [LOW_W-1:0] lowsum_t;
	typedef logic [COL_W-1:0] colsum_t;
	typedef logic [SUM_W-1:0] sum_t;
	typedef chan_t [NUM_CH-1:0] pix_t;

	typedef struct packed {
		pix_t upper;
		pix_t lower;
	} line_t;

	typedef enum logic [1:0] {
		SLOT_MAIN,
		SLOT_ROW_END,
		SLOT_LAST_ROW,
		SLOT_CORNER
	} slot_t;

	typedef enum logic [1:0] {
		DIV4,
		DIV6,
		DIV9
	} div_sel_t;

	function automatic logic [RECIP_W-1:0] recip_of(input div_sel_t sel);
		logic [RECIP_W-1:0] r;
		case (sel)
			DIV4:    r = RECIP_4;
			DIV6:    r = RECIP_6;
			DIV9:    r = RECIP_9;
			default: r = RECIP_4;
		endcase
		return r;
	endfunction

endpackage

FILE: sv/box_smooth_3x3.sv
// Top level of the 3x3 box smoothing block: line memory, window registers,
// result sequencer and output register. Depends on bsm_pkg.
//
// Usage: pixels enter in raster order on the input channel (in_valid,
// in_stall, red_in, green_in, blue_in). Smoothed pixels leave on the output
// channel (out_valid, out_stall) with their row and column, last_in_run on
// the final result caused by an input item and frame_end on the bottom-right
// pixel. cfg_wen with cfg_wdata sets the frame size (clamped to 2..MAX_DIM)
// and restarts the frame; write it only while the block is idle.
// A result caused by an item passes through the stage-one registers (memory
// read at the accepting edge), the window sums in stage two and the divide
// into the output register. Throughput: one item per cycle while each item
// causes at most one result and the receiver does not stall; an item causing
// more than one result (row ends, last row) holds the divide stage until all
// are taken and stalls the input meanwhile, since the single output register
// takes one result per cycle. A stalled receiver backs up into the sequencer
// and then stalls the input; nothing is lost. Reset sets the frame size to
// 512 and the position to the first pixel; the line memory needs no
// clearing, since rows that were never written are never part of a clipped
// neighbourhood.
module box_smooth_3x3 (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wen,
	input  logic [bsm_pkg::CFG_W-1:0]     cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [bsm_pkg::CH_W-1:0]      red_in,
	input  logic [bsm_pkg::CH_W-1:0]      green_in,
	input  logic [bsm_pkg::CH_W-1:0]      blue_in,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [bsm_pkg::CH_W-1:0]      red_out,
	output logic [bsm_pkg::CH_W-1:0]      green_out,
	output logic [bsm_pkg::CH_W-1:0]      blue_out,
	output logic [bsm_pkg::POS_W-1:0]     out_row,
	output logic [bsm_pkg::POS_W-1:0]     out_col,
	output logic                          last_in_run,
	output logic                          frame_end
);

	localparam int IDX_W = bsm_pkg::IDX_W;

	logic [IDX_W-1:0] last_q;
	logic [IDX_W-1:0] row_q;
	logic [IDX_W-1:0] col_q;
	logic [IDX_W-1:0] cfg_last;

	bsm_pkg::line_t line_mem [bsm_pkg::MAX_DIM];
	bsm_pkg::line_t line_s1;
	bsm_pkg::pix_t  pix_s1;
	logic [IDX_W-1:0] row_s1;
	logic [IDX_W-1:0] col_s1;
	logic           valid_s1;

	bsm_pkg::colsum_t [1:0][bsm_pkg::NUM_CH-1:0] full_q;
	bsm_pkg::lowsum_t [1:0][bsm_pkg::NUM_CH-1:0] low_q;

	bsm_pkg::sum_t [bsm_pkg::NUM_SLOTS-1:0][bsm_pkg::NUM_CH-1:0] sum_s2;
	logic [bsm_pkg::NUM_SLOTS-1:0] mask_s2;
	logic [IDX_W-1:0] row_s2;
	logic [IDX_W-1:0] col_s2;
	logic             cge2_s2;
	logic             rge2_s2;

	bsm_pkg::chan_t [bsm_pkg::NUM_CH-1:0] mean_q;
	logic [bsm_pkg::POS_W-1:0] out_row_q;
	logic [bsm_pkg::POS_W-1:0] out_col_q;
	logic out_valid_q;
	logic out_last_q;
	logic frame_end_q;

	logic in_accept;
	logic adv_s1;
	logic out_ready;
	logic emit;

	bsm_pkg::colsum_t [bsm_pkg::NUM_CH-1:0] cur_full;
	bsm_pkg::lowsum_t [bsm_pkg::NUM_CH-1:0] cur_low;
	bsm_pkg::sum_t [bsm_pkg::NUM_SLOTS-1:0][bsm_pkg::NUM_CH-1:0] tot;
	logic [bsm_pkg::NUM_SLOTS-1:0] mask_new;
	logic r_ge2;
	logic c_ge2;

	bsm_pkg::slot_t sel;
	logic [bsm_pkg::NUM_SLOTS-1:0] sel_oh;
	logic [bsm_pkg::NUM_SLOTS-1:0] mask_rest;
	logic [IDX_W-1:0] emit_row;
	logic [IDX_W-1:0] emit_col;
	logic cols3;
	logic rows3;
	bsm_pkg::div_sel_t div_sel;
	logic [bsm_pkg::RECIP_W-1:0] recip;
	logic [bsm_pkg::SUM_W+bsm_pkg::RECIP_W-1:0] prod [bsm_pkg::NUM_CH];

	always_comb begin
		if (cfg_wdata < bsm_pkg::CFG_W'(bsm_pkg::DIM_MIN)) begin
			cfg_last = IDX_W'(bsm_pkg::DIM_MIN - 1);
		end else if (int'(cfg_wdata) > bsm_pkg::MAX_DIM) begin
			cfg_last = IDX_W'(bsm_pkg::MAX_DIM - 1);
		end else begin
			cfg_last = IDX_W'(cfg_wdata - bsm_pkg::CFG_W'(1));
		end
	end

	assign out_ready = !out_valid_q || !out_stall;
	assign emit      = (mask_s2 != '0) && out_ready;
	assign adv_s1    = valid_s1 && ((mask_s2 == '0) || (emit && (mask_rest == '0)));
	assign in_stall  = valid_s1 && !adv_s1;
	assign in_accept = in_valid && !in_stall;

	always_comb begin
		r_ge2 = row_s1 > IDX_W'(1);
		c_ge2 = col_s1 > IDX_W'(1);
		for (int k = 0; k < bsm_pkg::NUM_CH; k++) begin
			cur_full[k] = bsm_pkg::COL_W'(line_s1.upper[k]) + bsm_pkg::COL_W'(line_s1.lower[k])
				+ bsm_pkg::COL_W'(pix_s1[k]);
			cur_low[k] = bsm_pkg::LOW_W'(line_s1.lower[k]) + bsm_pkg::LOW_W'(pix_s1[k]);
			tot[bsm_pkg::SLOT_MAIN][k] =
				(r_ge2 ? bsm_pkg::SUM_W'(full_q[1][k]) : bsm_pkg::SUM_W'(low_q[1][k]))
				+ (r_ge2 ? bsm_pkg::SUM_W'(cur_full[k]) : bsm_pkg::SUM_W'(cur_low[k]));
			tot[bsm_pkg::SLOT_ROW_END][k] = tot[bsm_pkg::SLOT_MAIN][k];
			if (c_ge2) begin
				tot[bsm_pkg::SLOT_MAIN][k] = tot[bsm_pkg::SLOT_MAIN][k]
					+ (r_ge2 ? bsm_pkg::SUM_W'(full_q[0][k]) : bsm_pkg::SUM_W'(low_q[0][k]));
			end
			tot[bsm_pkg::SLOT_CORNER][k] = bsm_pkg::SUM_W'(low_q[1][k])
				+ bsm_pkg::SUM_W'(cur_low[k]);
			tot[bsm_pkg::SLOT_LAST_ROW][k] = tot[bsm_pkg::SLOT_CORNER][k]
				+ (c_ge2 ? bsm_pkg::SUM_W'(low_q[0][k]) : '0);
		end
		mask_new[bsm_pkg::SLOT_MAIN]     = (row_s1 != '0) && (col_s1 != '0);
		mask_new[bsm_pkg::SLOT_ROW_END]  = (row_s1 != '0) && (col_s1 == last_q);
		mask_new[bsm_pkg::SLOT_LAST_ROW] = (row_s1 == last_q) && (col_s1 != '0);
		mask_new[bsm_pkg::SLOT_CORNER]   = (row_s1 == last_q) && (col_s1 == last_q);
	end

	always_comb begin
		if (mask_s2[bsm_pkg::SLOT_MAIN]) begin
			sel = bsm_pkg::SLOT_MAIN;
		end else if (mask_s2[bsm_pkg::SLOT_ROW_END]) begin
			sel = bsm_pkg::SLOT_ROW_END;
		end else if (mask_s2[bsm_pkg::SLOT_LAST_ROW]) begin
			sel = bsm_pkg::SLOT_LAST_ROW;
		end else begin
			sel = bsm_pkg::SLOT_CORNER;
		end
		sel_oh    = bsm_pkg::NUM_SLOTS'(1) << sel;
		mask_rest = mask_s2 & ~sel_oh;
		case (sel)
			bsm_pkg::SLOT_MAIN: begin
				emit_row = row_s2 - IDX_W'(1);
				emit_col = col_s2 - IDX_W'(1);
			end
			bsm_pkg::SLOT_ROW_END: begin
				emit_row = row_s2 - IDX_W'(1);
				emit_col = col_s2;
			end
			bsm_pkg::SLOT_LAST_ROW: begin
				emit_row = row_s2;
				emit_col = col_s2 - IDX_W'(1);
			end
			default: begin
				emit_row = row_s2;
				emit_col = col_s2;
			end
		endcase
		cols3 = cge2_s2 && ((sel == bsm_pkg::SLOT_MAIN) || (sel == bsm_pkg::SLOT_LAST_ROW));
		rows3 = rge2_s2 && ((sel == bsm_pkg::SLOT_MAIN) || (sel == bsm_pkg::SLOT_ROW_END));
		if (cols3 && rows3) begin
			div_sel = bsm_pkg::DIV9;
		end else if (cols3 || rows3) begin
			div_sel = bsm_pkg::DIV6;
		end else begin
			div_sel = bsm_pkg::DIV4;
		end
		recip = bsm_pkg::recip_of(div_sel);
		for (int k = 0; k < bsm_pkg::NUM_CH; k++) begin
			prod[k] = (bsm_pkg::SUM_W + bsm_pkg::RECIP_W)'(sum_s2[sel][k])
				* (bsm_pkg::SUM_W + bsm_pkg::RECIP_W)'(recip);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q      <= IDX_W'(bsm_pkg::DIM_RESET - 1);
			row_q       <= '0;
			col_q       <= '0;
			valid_s1    <= 1'b0;
			mask_s2     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wen) begin
				last_q <= cfg_last;
				row_q  <= '0;
				col_q  <= '0;
			end else if (in_accept) begin
				if (col_q == last_q) begin
					col_q <= '0;
					row_q <= (row_q == last_q) ? '0 : row_q + IDX_W'(1);
				end else begin
					col_q <= col_q + IDX_W'(1);
				end
			end
			if (in_accept) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				mask_s2 <= mask_new;
			end else if (emit) begin
				mask_s2 <= mask_rest;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			line_s1 <= line_mem[col_q];
		end
		if (adv_s1) begin
			line_mem[col_s1] <= '{upper: line_s1.lower, lower: pix_s1};
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			pix_s1 <= '{blue_in, green_in, red_in};
			row_s1 <= row_q;
			col_s1 <= col_q;
		end
		if (adv_s1) begin
			full_q[0] <= full_q[1];
			low_q[0]  <= low_q[1];
			full_q[1] <= cur_full;
			low_q[1]  <= cur_low;
			sum_s2    <= tot;
			row_s2    <= row_s1;
			col_s2    <= col_s1;
			cge2_s2   <= c_ge2;
			rge2_s2   <= r_ge2;
		end
		if (emit) begin
			for (int k = 0; k < bsm_pkg::NUM_CH; k++) begin
				mean_q[k] <= prod[k][bsm_pkg::RECIP_SHIFT +: bsm_pkg::CH_W];
			end
			out_row_q   <= bsm_pkg::POS_W'(emit_row);
			out_col_q   <= bsm_pkg::POS_W'(emit_col);
			out_last_q  <= (mask_rest == '0);
			frame_end_q <= (sel == bsm_pkg::SLOT_CORNER);
		end
	end

	assign out_valid   = out_valid_q;
	assign red_out     = mean_q[0];
	assign green_out   = mean_q[1];
	assign blue_out    = mean_q[2];
	assign out_row     = out_row_q;
	assign out_col     = out_col_q;
	assign last_in_run = out_last_q;
	assign frame_end   = frame_end_q;

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && adv_s1) |-> (col_q != col_s1))
		else $error("Line memory read and write hit the same entry.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && valid_s1) |-> adv_s1)
		else $error("Item in stage one overwritten before it advanced.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && frame_end) |-> (last_in_run && (out_row == out_col)))
		else $error("Frame end result is not the last of its run.");
`endif

endmodule
